// ----- sv/cia_pkg.sv -----
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants of the complex integer ALU
// Operation codes, widths and the item record that moves down the divider row.
// ----------------------------------------------------------------------------
package cia_pkg;

  // Operation codes.
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // Quotient width: one divider cell per quotient bit.
  localparam int QW = 32;

  // Result saturation bound.
  localparam logic signed [33:0] RES_MAX = 34'sd2147483647;

  // Item record carried through the divider cells.
  typedef struct packed {
    logic [1:0]         cmd;
    logic               err;
    logic               neg_re;
    logic               neg_im;
    logic signed [32:0] dir_re;
    logic signed [32:0] dir_im;
    logic [QW-1:0]      num_re;
    logic [QW-1:0]      num_im;
    logic [QW-1:0]      rem_re;
    logic [QW-1:0]      rem_im;
    logic [QW-1:0]      den;
  } cell_t;

endpackage

// ----- sv/cia_front.sv -----
// ----------------------------------------------------------------------------
// cia_front: operand stages of the complex integer ALU
// Stage one forms all partial products and the narrow sums, stage two the direct results,
// the divide numerator magnitudes and the divisor's squared magnitude.
// ----------------------------------------------------------------------------
module cia_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] a_real,
  input  logic signed [15:0] a_imag,
  input  logic signed [15:0] b_real,
  input  logic signed [15:0] b_imag,
  output logic               out_valid,
  output cia_pkg::cell_t     out_data,
  input  logic               out_ready
);

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [16:0] add_re;
    logic signed [16:0] add_im;
    logic signed [16:0] sub_re;
    logic signed [16:0] sub_im;
    logic signed [31:0] p_rr;
    logic signed [31:0] p_ii;
    logic signed [31:0] p_ri;
    logic signed [31:0] p_ir;
    logic signed [31:0] sq_r;
    logic signed [31:0] sq_i;
  } s1_t;

  logic           s1_valid_r;
  s1_t            s1_r;
  s1_t            s1_nxt;
  logic           s1_ready;
  logic           s2_valid_r;
  cia_pkg::cell_t s2_r;
  cia_pkg::cell_t s2_nxt;
  logic           s2_ready;
  logic signed [32:0] n_re;
  logic signed [32:0] n_im;

  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage one: products and the narrow sums.
  always_comb begin
    s1_nxt.cmd    = cmd;
    s1_nxt.add_re = 17'(a_real) + 17'(b_real);
    s1_nxt.add_im = 17'(a_imag) + 17'(b_imag);
    s1_nxt.sub_re = 17'(a_real) - 17'(b_real);
    s1_nxt.sub_im = 17'(a_imag) - 17'(b_imag);
    s1_nxt.p_rr   = 32'(a_real * b_real);
    s1_nxt.p_ii   = 32'(a_imag * b_imag);
    s1_nxt.p_ri   = 32'(a_real * b_imag);
    s1_nxt.p_ir   = 32'(a_imag * b_real);
    s1_nxt.sq_r   = 32'(b_real * b_real);
    s1_nxt.sq_i   = 32'(b_imag * b_imag);
  end

  // Stage two: direct results, numerators and divisor.
  always_comb begin
    n_re = 33'(s1_r.p_rr) + 33'(s1_r.p_ii);
    n_im = 33'(s1_r.p_ir) - 33'(s1_r.p_ri);
    s2_nxt = '0;
    s2_nxt.cmd    = s1_r.cmd;
    s2_nxt.den    = 32'(s1_r.sq_r) + 32'(s1_r.sq_i);
    s2_nxt.err    = (s1_r.cmd == cia_pkg::CMD_DIV) && (s2_nxt.den == '0);
    s2_nxt.neg_re = n_re[32];
    s2_nxt.neg_im = n_im[32];
    s2_nxt.num_re = n_re[32] ? 32'(-n_re) : 32'(n_re);
    s2_nxt.num_im = n_im[32] ? 32'(-n_im) : 32'(n_im);
    case (s1_r.cmd)
      cia_pkg::CMD_ADD: begin
        s2_nxt.dir_re = 33'(s1_r.add_re);
        s2_nxt.dir_im = 33'(s1_r.add_im);
      end
      cia_pkg::CMD_SUB: begin
        s2_nxt.dir_re = 33'(s1_r.sub_re);
        s2_nxt.dir_im = 33'(s1_r.sub_im);
      end
      cia_pkg::CMD_MUL: begin
        s2_nxt.dir_re = 33'(s1_r.p_rr) - 33'(s1_r.p_ii);
        s2_nxt.dir_im = 33'(s1_r.p_ri) + 33'(s1_r.p_ir);
      end
      default: begin
        s2_nxt.dir_re = '0;
        s2_nxt.dir_im = '0;
      end
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) s1_r <= s1_nxt;
    if (s2_ready && s1_valid_r) s2_r <= s2_nxt;
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_r;

endmodule

// ----- sv/cia_cell.sv -----
// ----------------------------------------------------------------------------
// cia_cell: one restoring division cell
// Develops one quotient bit of both the real and the imaginary part.
// ----------------------------------------------------------------------------
module cia_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cia_pkg::cell_t in_data,
  output logic           out_valid,
  output cia_pkg::cell_t out_data,
  input  logic           out_ready
);

  logic           valid_r;
  cia_pkg::cell_t data_r;
  cia_pkg::cell_t data_nxt;
  logic [cia_pkg::QW:0] sh_re;
  logic [cia_pkg::QW:0] sh_im;
  logic                 ge_re;
  logic                 ge_im;

  assign in_ready = !valid_r || out_ready;

  // Shift in the next numerator bit, subtract the divisor when it fits.
  always_comb begin
    sh_re = {in_data.rem_re, in_data.num_re[cia_pkg::QW-1]};
    sh_im = {in_data.rem_im, in_data.num_im[cia_pkg::QW-1]};
    ge_re = sh_re >= {1'b0, in_data.den};
    ge_im = sh_im >= {1'b0, in_data.den};
    data_nxt = in_data;
    data_nxt.rem_re = ge_re ? cia_pkg::QW'(sh_re - {1'b0, in_data.den})
                            : sh_re[cia_pkg::QW-1:0];
    data_nxt.rem_im = ge_im ? cia_pkg::QW'(sh_im - {1'b0, in_data.den})
                            : sh_im[cia_pkg::QW-1:0];
    data_nxt.num_re = {in_data.num_re[cia_pkg::QW-2:0], ge_re};
    data_nxt.num_im = {in_data.num_im[cia_pkg::QW-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- sv/cia_back.sv -----
// ----------------------------------------------------------------------------
// cia_back: result stage of the complex integer ALU
// Picks direct or quotient result, applies sign and saturation, holds output.
// ----------------------------------------------------------------------------
module cia_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cia_pkg::cell_t     in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] res_real,
  output logic signed [31:0] res_imag,
  output logic               div_by_zero
);

  logic               valid_r;
  logic signed [31:0] re_r;
  logic signed [31:0] im_r;
  logic               err_r;
  logic signed [33:0] v_re;
  logic signed [33:0] v_im;
  logic signed [31:0] re_nxt;
  logic signed [31:0] im_nxt;

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > cia_pkg::RES_MAX) r = 32'(cia_pkg::RES_MAX);
    else if (v < -cia_pkg::RES_MAX) r = 32'(-cia_pkg::RES_MAX);
    else r = v[31:0];
    return r;
  endfunction

  assign in_ready = !valid_r || !out_stall;

  // Select the result and saturate it.
  always_comb begin
    if (in_data.cmd == cia_pkg::CMD_DIV) begin
      v_re = in_data.neg_re ? -34'({2'b00, in_data.num_re}) : 34'({2'b00, in_data.num_re});
      v_im = in_data.neg_im ? -34'({2'b00, in_data.num_im}) : 34'({2'b00, in_data.num_im});
    end else begin
      v_re = 34'(in_data.dir_re);
      v_im = 34'(in_data.dir_im);
    end
    re_nxt = in_data.err ? '0 : sat(v_re);
    im_nxt = in_data.err ? '0 : sat(v_im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      re_r  <= re_nxt;
      im_r  <= im_nxt;
      err_r <= in_data.err;
    end
  end

  assign out_valid   = valid_r;
  assign res_real    = re_r;
  assign res_imag    = im_r;
  assign div_by_zero = err_r;

endmodule

// ----- sv/complex_integer_alu_top.sv -----
// ----------------------------------------------------------------------------
// complex_integer_alu_top: pipelined complex add, subtract, multiply, divide
// An accepted item passes through two operand stages, 32 division cells and
// the output register to its result. Throughput is one item per cycle while
// out_stall is low; every stage holds its own item and stalls only when full.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module complex_integer_alu_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [15:0] in_a_real,
  input  logic signed [15:0] in_a_imag,
  input  logic signed [15:0] in_b_real,
  input  logic signed [15:0] in_b_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_res_real,
  output logic signed [31:0] out_res_imag,
  output logic               out_div_by_zero
);

  logic                 front_ready;
  logic                 v   [cia_pkg::QW+1];
  logic                 rdy [cia_pkg::QW+1];
  cia_pkg::cell_t       d   [cia_pkg::QW+1];

  assign in_stall = !front_ready;

  // Operand stages.
  cia_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .cmd       (in_cmd),
    .a_real    (in_a_real),
    .a_imag    (in_a_imag),
    .b_real    (in_b_real),
    .b_imag    (in_b_imag),
    .out_valid (v[0]),
    .out_data  (d[0]),
    .out_ready (rdy[0])
  );

  // Row of division cells, one quotient bit each.
  for (genvar i = 0; i < cia_pkg::QW; i++) begin : g_cell
    cia_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v[i]),
      .in_ready  (rdy[i]),
      .in_data   (d[i]),
      .out_valid (v[i+1]),
      .out_data  (d[i+1]),
      .out_ready (rdy[i+1])
    );
  end

  // Result stage.
  cia_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (v[cia_pkg::QW]),
    .in_ready    (rdy[cia_pkg::QW]),
    .in_data     (d[cia_pkg::QW]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res_real    (out_res_real),
    .res_imag    (out_res_imag),
    .div_by_zero (out_div_by_zero)
  );

  // A divide error always comes with zero parts.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |-> out_res_real == 0 && out_res_imag == 0)
    else $error("divide error result with nonzero parts");

  // Saturation never lets the most negative code through.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res_real != 32'sh80000000 && out_res_imag != 32'sh80000000)
    else $error("result outside saturation range");

  // After reset the pipeline is empty and takes an item.
  a_reset_ready: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_stall && !out_valid)
    else $error("pipeline not empty after reset");

endmodule

// ----- bench/complex_integer_alu_top_tb.sv -----
// ----------------------------------------------------------------------------
// complex_integer_alu_top_tb: self-checking bench for the complex integer ALU
// Drives operand items through the valid/stall handshake, predicts each
// result in the bench and compares every field of every result in order.
// ----------------------------------------------------------------------------
module complex_integer_alu_top_tb;

  // Expected result record.
  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               dz;
  } cres_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_cmd;
  logic signed [15:0] in_a_real;
  logic signed [15:0] in_a_imag;
  logic signed [15:0] in_b_real;
  logic signed [15:0] in_b_imag;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_res_real;
  logic signed [31:0] out_res_imag;
  logic               out_div_by_zero;

  cres_t  pending_results[$];
  int     error_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  bit     hold_off_req;
  int     idle_cycles;

  complex_integer_alu_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_a_real(in_a_real), .in_a_imag(in_a_imag),
    .in_b_real(in_b_real), .in_b_imag(in_b_imag),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_real(out_res_real), .out_res_imag(out_res_imag),
    .out_div_by_zero(out_div_by_zero)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Saturate a wide intermediate to the symmetric 32-bit result range.
  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sd2147483647;
    if (v < -64'sd2147483647) return -32'sd2147483647;
    return v[31:0];
  endfunction

  // Compute the complex result that one operand item yields.
  function automatic cres_t complex_result(input logic [1:0] cmd,
      input logic signed [15:0] ar, input logic signed [15:0] ai,
      input logic signed [15:0] br, input logic signed [15:0] bi);
    cres_t  r;
    longint xr, xi, yr, yi, re, im, den;
    xr = longint'(ar); xi = longint'(ai); yr = longint'(br); yi = longint'(bi);
    re = 0; im = 0;
    r.dz = 1'b0;
    case (cmd)
      cia_pkg::CMD_ADD: begin re = xr + yr; im = xi + yi; end
      cia_pkg::CMD_SUB: begin re = xr - yr; im = xi - yi; end
      cia_pkg::CMD_MUL: begin
        re = xr * yr - xi * yi;
        im = xr * yi + xi * yr;
      end
      default: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          // SystemVerilog division truncates toward zero.
          re = (xr * yr + xi * yi) / den;
          im = (xi * yr - xr * yi) / den;
        end
      end
    endcase
    r.re = sat32(re);
    r.im = sat32(im);
    return r;
  endfunction

  // Offer one item, hold it until accepted, and record its expectation.
  task automatic send_item(input logic [1:0] cmd, input logic signed [15:0] ar,
      input logic signed [15:0] ai, input logic signed [15:0] br,
      input logic signed [15:0] bi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_a_real <= ar;
    in_a_imag <= ai;
    in_b_real <= br;
    in_b_imag <= bi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(complex_result(cmd, ar, ai, br, bi));
  endtask

  // Random operand: mostly in range, sometimes extremes or any 16-bit pattern.
  function automatic logic signed [15:0] rand_operand();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return -16'sd32767;
      2: return 16'sh8000;
      3: return 16'($urandom_range(7) - 3);
      4, 5: return 16'($urandom);
      default: return 16'($urandom_range(65534) - 32767);
    endcase
  endfunction

  // Stop offering and wait until every expected result has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Directed extremes, every operation and the divide-by-zero case.
  task automatic test_directed();
    logic [1:0] c;
    for (int k = 0; k < 4; k++) begin
      c = k[1:0];
      send_item(c, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_item(c, -16'sd32767, 16'sh7FFF, 16'sh7FFF, -16'sd32767);
      send_item(c, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_item(c, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0001);
    end
    send_item(cia_pkg::CMD_DIV, 16'sd100, -16'sd7, 16'sd0, 16'sd0);
    send_item(cia_pkg::CMD_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(cia_pkg::CMD_DIV, -16'sd7, 16'sd7, 16'sd2, 16'sd0);
    send_item(cia_pkg::CMD_DIV, 16'sd7, -16'sd9, 16'sd0, -16'sd2);
    send_item(cia_pkg::CMD_DIV, 16'sd1, 16'sd1, 16'sd3, 16'sd4);
    send_item(cia_pkg::CMD_MUL, 16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF);
    wait_drained();
  endtask

  task automatic test_random(input int n);
    logic signed [15:0] br, bi;
    for (int k = 0; k < n; k++) begin
      br = rand_operand();
      bi = rand_operand();
      if ($urandom_range(15) == 0) begin br = '0; bi = '0; end
      send_item(2'($urandom_range(3)), rand_operand(), rand_operand(), br, bi);
    end
    wait_drained();
  endtask

  // Receiver holds off while items keep coming, so the pipeline backs up.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    test_random(60);
    // The sender then pauses until everything has drained.
    test_random(5);
  endtask

  // Receiver stall generation, with a long hold-off counted here.
  initial begin
    int hold;
    out_stall <= 1'b1;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        for (hold = 0; hold < 200; hold++) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      @(posedge clk);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    cres_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d dz=%0b", $time,
                 out_res_real, out_res_imag, out_div_by_zero);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_res_real !== e.re) begin
          $display("%0t: res_real expected %0d actual %0d", $time, e.re, out_res_real);
          error_count++;
        end
        if (out_res_imag !== e.im) begin
          $display("%0t: res_imag expected %0d actual %0d", $time, e.im, out_res_imag);
          error_count++;
        end
        if (out_div_by_zero !== e.dz) begin
          $display("%0t: div_by_zero expected %0b actual %0b", $time, e.dz,
                   out_div_by_zero);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item or taken result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    error_count   = 0;
    idle_cycles   = 0;
    hold_off_req  = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 67;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_cmd    <= cia_pkg::CMD_ADD;
    in_a_real <= '0;
    in_a_imag <= '0;
    in_b_real <= '0;
    in_b_imag <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(200);
    send_idle_pct = 67;
    recv_idle_pct = 23;
    test_random(180);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(180);
    test_backpressure();

    // Let the pipeline settle past its latency.
    repeat (60) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
